/* rtl/utf8_text_page_cursor_writer_top_assert.svh */
// ----------------------------------------------------------------------------
// utf8 text page cursor writer: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_PAGE_CURSOR_WRITER_TOP_ASSERT_SVH
`define UTF8_TEXT_PAGE_CURSOR_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define TPCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tpcw_pkg.sv */
// ----------------------------------------------------------------------------
// tpcw_pkg
// types and constants shared by the utf8 text page cursor writer
// ----------------------------------------------------------------------------
package tpcw_pkg;

	localparam int unsigned MAX_ROWS = 512;
	localparam int unsigned MAX_COLS = 512;

	localparam logic [9:0] PAGE_RESET = 10'd512;
	localparam logic [9:0] MAX_ROWS_V = 10'(MAX_ROWS);
	localparam logic [9:0] MAX_COLS_V = 10'(MAX_COLS);

	localparam logic [20:0] CP_NEWLINE = 21'h00000A;

	typedef enum logic [1:0] {
		REQ_TEXT        = 2'd0,
		REQ_SET_ROW_COL = 2'd1,
		REQ_SET_ROW     = 2'd2,
		REQ_SET_COL     = 2'd3
	} req_type_t;

	typedef enum logic {
		CFG_PAGE_ROWS = 1'b0,
		CFG_PAGE_COLS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic       last_of_string;
		logic [9:0] target_row;
		logic [9:0] target_col;
	} in_item_t;

	typedef struct packed {
		logic        cell_write;
		logic [17:0] cell_address;
		logic [20:0] codepoint;
		logic        command_error;
		logic [9:0]  cursor_row;
		logic [9:0]  cursor_col;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  pending;
		logic [20:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] col;
	} cursor_t;

	typedef struct packed {
		logic        emit;
		logic [20:0] codepoint;
	} dec_out_t;

endpackage

/* rtl/utf8_text_page_cursor_writer_top.sv */
// ----------------------------------------------------------------------------
// utf8_text_page_cursor_writer_top
// utf8 text decoder with row/column cursor for a character page
// ----------------------------------------------------------------------------
// in_data carries one text byte or one cursor command per transfer on the
// in_valid/in_ready channel; every item gives exactly one result on the
// out_valid/out_ready channel: an optional cell write (address, codepoint),
// the command error flag and the cursor position after the item.
// An item is taken into an input register, then decoded and applied to the cursor,
// and the result lands in the output register, which drives out_valid. One item
// per cycle is sustained while out_ready stays high; the cursor and decoder state
// update in one pass per item.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; after that in_ready drops until
// out_ready returns.
// Page size is written through cfg_we/cfg_index/cfg_data while no item is in
// flight; zero acts as one and large values clamp to the page maximum.
// Reset clears both registers, the decoder, the ignore flag, puts the cursor
// at row 1 column 1 and the page size at 512 by 512.
// ----------------------------------------------------------------------------
`include "utf8_text_page_cursor_writer_top_assert.svh"

module utf8_text_page_cursor_writer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tpcw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tpcw_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data
);

	logic                 valid_s1;
	tpcw_pkg::in_item_t   item_s1;
	logic                 out_valid_q;
	tpcw_pkg::out_item_t  out_q;
	logic [9:0]           rows_q;
	logic [9:0]           cols_q;
	tpcw_pkg::dec_state_t dec_q;
	tpcw_pkg::dec_state_t dec_nxt;
	tpcw_pkg::cursor_t    cur_q;
	tpcw_pkg::cursor_t    cur_nxt;
	logic                 ignore_q;
	logic                 advance;
	logic                 is_text;
	logic                 end_of_string;
	logic                 page_end;
	logic [9:0]           cfg_clamped;
	tpcw_pkg::dec_out_t   dec_out;
	tpcw_pkg::out_item_t  result;

	assign advance       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready      = !valid_s1 || advance;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign is_text       = (item_s1.req_type == tpcw_pkg::REQ_TEXT);
	assign end_of_string = is_text && item_s1.last_of_string;

	// both registers share the same clamp since the maxima are equal in width
	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data == 10'd0) begin
			cfg_clamped = 10'd1;
		end else if ((cfg_index == tpcw_pkg::CFG_PAGE_ROWS) &&
				(cfg_data > tpcw_pkg::MAX_ROWS_V)) begin
			cfg_clamped = tpcw_pkg::MAX_ROWS_V;
		end else if ((cfg_index == tpcw_pkg::CFG_PAGE_COLS) &&
				(cfg_data > tpcw_pkg::MAX_COLS_V)) begin
			cfg_clamped = tpcw_pkg::MAX_COLS_V;
		end
	end

	tpcw_decode u_decode (
		.active    (valid_s1 && is_text && !ignore_q),
		.data_byte (item_s1.data_byte),
		.state     (dec_q),
		.state_nxt (dec_nxt),
		.result    (dec_out)
	);

	tpcw_cursor u_cursor (
		.rows       (rows_q),
		.cols       (cols_q),
		.cursor     (cur_q),
		.item_valid (valid_s1),
		.item       (item_s1),
		.dec        (dec_out),
		.cursor_nxt (cur_nxt),
		.result     (result),
		.page_end   (page_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= tpcw_pkg::PAGE_RESET;
			cols_q <= tpcw_pkg::PAGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpcw_pkg::CFG_PAGE_ROWS: rows_q <= cfg_clamped;
				tpcw_pkg::CFG_PAGE_COLS: cols_q <= cfg_clamped;
				default: rows_q <= rows_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= '0;
			cur_q.row <= 10'd1;
			cur_q.col <= 10'd1;
			ignore_q  <= 1'b0;
		end else if (advance) begin
			cur_q <= cur_nxt;
			if (end_of_string) begin
				dec_q    <= '0;
				ignore_q <= 1'b0;
			end else begin
				dec_q    <= dec_nxt;
				ignore_q <= ignore_q | page_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	`TPCW_ASSERT_NOW(a_partial_idle, dec_q.pending == 2'd0, dec_q.partial == 21'd0,
		"partial codepoint left over with no sequence open")
	`TPCW_ASSERT_NOW(a_no_write_fields, out_valid_q && !out_q.cell_write,
		(out_q.cell_address == 18'd0) && (out_q.codepoint == 21'd0),
		"cell fields nonzero without a cell write")
	`TPCW_ASSERT_NOW(a_err_no_write, out_valid_q && out_q.command_error,
		!out_q.cell_write, "cell write reported on a failed command")
	`TPCW_ASSERT_NEXT(a_cursor_follow, advance,
		(cur_q.row == out_q.cursor_row) && (cur_q.col == out_q.cursor_col),
		"reported cursor differs from cursor state")

endmodule

/* rtl/tpcw_decode.sv */
// ----------------------------------------------------------------------------
// tpcw_decode
// utf8 byte decoder step: continuation check, lead byte start, codepoint out
// ----------------------------------------------------------------------------
module tpcw_decode (
	input  logic                 active,
	input  logic [7:0]           data_byte,
	input  tpcw_pkg::dec_state_t state,
	output tpcw_pkg::dec_state_t state_nxt,
	output tpcw_pkg::dec_out_t   result
);

	logic        is_cont;
	logic [20:0] merged;

	assign is_cont = (data_byte[7:6] == 2'b10);
	assign merged  = {state.partial[14:0], data_byte[5:0]};

	always_comb begin
		state_nxt        = state;
		result.emit      = 1'b0;
		result.codepoint = '0;
		if (active) begin
			if ((state.pending != 2'd0) && is_cont) begin
				if (state.pending == 2'd1) begin
					result.emit      = 1'b1;
					result.codepoint = merged;
					state_nxt        = '0;
				end else begin
					state_nxt.pending = state.pending - 2'd1;
					state_nxt.partial = merged;
				end
			end else begin
				// no sequence open, or a bad continuation: take the byte as a lead
				state_nxt = '0;
				if (data_byte[7] == 1'b0) begin
					result.emit      = 1'b1;
					result.codepoint = {13'd0, data_byte};
				end else if (data_byte[7:5] == 3'b110) begin
					state_nxt.pending = 2'd1;
					state_nxt.partial = {16'd0, data_byte[4:0]};
				end else if (data_byte[7:4] == 4'b1110) begin
					state_nxt.pending = 2'd2;
					state_nxt.partial = {17'd0, data_byte[3:0]};
				end else if (data_byte[7:3] == 5'b11110) begin
					state_nxt.pending = 2'd3;
					state_nxt.partial = {18'd0, data_byte[2:0]};
				end
			end
		end
	end

endmodule

/* rtl/tpcw_cursor.sv */
// ----------------------------------------------------------------------------
// tpcw_cursor
// cursor update for codepoints and position commands, cell address compute
// ----------------------------------------------------------------------------
module tpcw_cursor (
	input  logic [9:0]         rows,
	input  logic [9:0]         cols,
	input  tpcw_pkg::cursor_t  cursor,
	input  logic               item_valid,
	input  tpcw_pkg::in_item_t item,
	input  tpcw_pkg::dec_out_t dec,
	output tpcw_pkg::cursor_t  cursor_nxt,
	output tpcw_pkg::out_item_t result,
	output logic               page_end
);

	logic        on_page;
	logic        newline;
	logic        wrap;
	logic        adv_row;
	logic        row_ok;
	logic        col_ok;
	logic [9:0]  row_inc;
	logic [9:0]  col_inc;
	logic [9:0]  row_m1;
	logic [9:0]  col_m1;
	logic [19:0] product;
	logic [19:0] addr_sum;

	assign row_inc  = cursor.row + 10'd1;
	assign col_inc  = cursor.col + 10'd1;
	assign row_m1   = cursor.row - 10'd1;
	assign col_m1   = cursor.col - 10'd1;
	assign product  = {10'd0, row_m1} * {10'd0, cols};
	assign addr_sum = product + {10'd0, col_m1};

	assign on_page = (cursor.row != 10'd0) && (cursor.row <= rows) &&
		(cursor.col != 10'd0) && (cursor.col <= cols);
	assign newline = dec.emit && (dec.codepoint == tpcw_pkg::CP_NEWLINE);
	assign wrap    = col_inc > cols;
	assign adv_row = newline || (dec.emit && wrap);
	assign row_ok  = (item.target_row != 10'd0) && (item.target_row <= rows);
	assign col_ok  = (item.target_col != 10'd0) && (item.target_col <= cols);

	always_comb begin
		cursor_nxt           = cursor;
		page_end             = 1'b0;
		result.cell_write    = 1'b0;
		result.cell_address  = '0;
		result.codepoint     = '0;
		result.command_error = 1'b0;
		if (item_valid) begin
			unique case (item.req_type)
				tpcw_pkg::REQ_TEXT: begin
					if (dec.emit && !newline && on_page) begin
						result.cell_write   = 1'b1;
						result.cell_address = addr_sum[17:0];
						result.codepoint    = dec.codepoint;
					end
					if (adv_row) begin
						cursor_nxt.col = 10'd1;
						if (row_inc > rows) begin
							cursor_nxt.row = rows + 10'd1;
							page_end       = 1'b1;
						end else begin
							cursor_nxt.row = row_inc;
						end
					end else if (dec.emit) begin
						cursor_nxt.col = col_inc;
					end
				end
				tpcw_pkg::REQ_SET_ROW_COL: begin
					if (row_ok && col_ok) begin
						cursor_nxt.row = item.target_row;
						cursor_nxt.col = item.target_col;
					end else begin
						result.command_error = 1'b1;
					end
				end
				tpcw_pkg::REQ_SET_ROW: begin
					if (row_ok) begin
						cursor_nxt.row = item.target_row;
						cursor_nxt.col = 10'd1;
					end else begin
						result.command_error = 1'b1;
					end
				end
				tpcw_pkg::REQ_SET_COL: begin
					if (col_ok) begin
						cursor_nxt.col = item.target_col;
					end else begin
						result.command_error = 1'b1;
					end
				end
				default: begin
					result.command_error = 1'b0;
				end
			endcase
		end
		result.cursor_row = cursor_nxt.row;
		result.cursor_col = cursor_nxt.col;
	end

endmodule
